// ===== hdl/bts_pkg.sv =====
// Shared types, constants and codes of the bilinear texture sampler.
`timescale 1ns / 1ps
package bts_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int FRAC_BITS  = 8;
   localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

   localparam int CRD_W    = 24;
   localparam int XH_W     = CRD_W + 1;
   localparam int IDX_W    = XH_W - FRAC_BITS;
   localparam int N_W      = IDX_W - 1;
   localparam int SIZE_W   = $clog2(MAX_DIM) + 1;
   localparam int POS_W    = $clog2(MAX_DIM);
   localparam int ADDR_W   = 16;
   localparam int TEXEL_W  = 32;
   localparam int CHAN_W   = 8;
   localparam int WGT_W    = 2 * FRAC_BITS + 1;
   localparam int PROD_W   = WGT_W + CHAN_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam int AM_RAW   = POS_W + SIZE_W + 1;
   localparam int AM_W     = (AM_RAW > ADDR_W) ? AM_RAW : ADDR_W;

   localparam int CSR_SIZE_W = 9;
   localparam int CSR_DATA_W = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CMP_W      = (SIZE_W > CSR_SIZE_W) ? SIZE_W + 1 : CSR_SIZE_W + 1;

   localparam int MID_DEPTH    = 32;
   localparam int MID_PTR_W    = $clog2(MID_DEPTH);
   localparam int CNT_W        = $clog2(MID_DEPTH + 1);
   localparam int FRONT_STAGES = N_W + 3;
   localparam int OUT_DEPTH    = 4;
   localparam int OUT_PTR_W    = $clog2(OUT_DEPTH);
   localparam int OCNT_W       = $clog2(OUT_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_TEX_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_H_MODE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_V_MODE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_MODE  = 3'd4;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      MODE_NONE    = 2'd0,
      MODE_PAD     = 2'd1,
      MODE_REFLECT = 2'd2,
      MODE_REPEAT  = 2'd3
   } mode_type;

   typedef struct packed {
      logic                      req_type;
      logic [ADDR_W-1:0]         texel_addr;
      logic [TEXEL_W-1:0]        texel_rgba;
      logic signed [CRD_W-1:0]   coord_x;
      logic signed [CRD_W-1:0]   coord_y;
      logic                      span_last;
   } req_item_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
      logic              span_end;
   } rsp_item_type;

   typedef struct packed {
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
      mode_type          h_mode;
      mode_type          v_mode;
      logic              fast;
   } cfg_type;

   typedef struct packed {
      logic                    is_load;
      logic [ADDR_W-1:0]       load_addr;
      logic [TEXEL_W-1:0]      rgba;
      logic                    span_last;
      logic [3:0][ADDR_W-1:0]  addr;
      logic [3:0]              ok;
      logic [3:0][WGT_W-1:0]   wgt;
   } mid_item_type;

   typedef struct packed {
      logic             push;
      logic [CNT_W-1:0] fill;
   } front_stat_type;

   typedef struct packed {
      logic             empty;
      logic [CNT_W-1:0] fill;
   } queue_stat_type;

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             ok;
   } pick_type;

endpackage

// ===== hdl/bilinear_texture_sampler.sv =====
// Top level of the bilinear texture sampler: configuration registers and flow control.
// Usage:
//   req_* is a queue input: an item transfers when req_push is high and req_full low.
//   Load items (req_type 0) write one texel and give no result; sample items give one.
//   rsp_* is a queue output: the oldest result is on rsp_data while rsp_empty is low and
//   transfers when rsp_pop is high.
//   csr_* writes one register per transfer (csr_valid with csr_ready, which is always high):
//   0 width, 1 height, 2 h_mode, 3 v_mode, 4 fast_mode; other indexes are dropped.
//   Write configuration only while no item is in flight.
// Timing:
//   One item per cycle sustained while req_full is low. A sample result passes through
//   the bit-per-cycle floor division per axis, mapping and addressing, the queue hop,
//   the registered texel store read and two blend stages.
// Reset:
//   Registers go to width 256, height 256, modes none, bilinear; queues empty.
//   The texel store is not cleared and holds nothing defined until loaded.
// Stall:
//   Results hold on rsp_data; the back end stops popping sample items (loads still drain)
//   once the result queue is committed, and req_full rises when front end plus queue reach 32 items.
`timescale 1ns / 1ps
module bilinear_texture_sampler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  bts_pkg::req_item_type             req_data,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output bts_pkg::rsp_item_type             rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bts_pkg::CSR_DATA_W-1:0]    csr_data
);

   function automatic logic [bts_pkg::SIZE_W-1:0] eff_size(logic [bts_pkg::CSR_SIZE_W-1:0] v,
                                                           int maxv);
      logic [bts_pkg::CMP_W-1:0] e;
      e = bts_pkg::CMP_W'(v);
      if (e == '0) begin
         return bts_pkg::SIZE_W'(1);
      end else if (e > bts_pkg::CMP_W'(maxv)) begin
         return bts_pkg::SIZE_W'(maxv);
      end
      return bts_pkg::SIZE_W'(e);
   endfunction

   logic [bts_pkg::CSR_SIZE_W-1:0] width_ff;
   logic [bts_pkg::CSR_SIZE_W-1:0] height_ff;
   bts_pkg::mode_type              h_mode_ff;
   bts_pkg::mode_type              v_mode_ff;
   logic                           fast_ff;
   bts_pkg::cfg_type               cfg;
   bts_pkg::front_stat_type        f_stat;
   bts_pkg::queue_stat_type        q_stat;
   bts_pkg::mid_item_type          f_item;
   bts_pkg::mid_item_type          q_head;
   logic                           accept;
   logic                           q_pop;
   logic [bts_pkg::CNT_W:0]        committed;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bts_pkg::CSR_SIZE_W'(256);
         height_ff <= bts_pkg::CSR_SIZE_W'(256);
         h_mode_ff <= bts_pkg::MODE_NONE;
         v_mode_ff <= bts_pkg::MODE_NONE;
         fast_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bts_pkg::CSR_TEX_WIDTH:  width_ff  <= csr_data;
            bts_pkg::CSR_TEX_HEIGHT: height_ff <= csr_data;
            bts_pkg::CSR_H_MODE:     h_mode_ff <= bts_pkg::mode_type'(csr_data[1:0]);
            bts_pkg::CSR_V_MODE:     v_mode_ff <= bts_pkg::mode_type'(csr_data[1:0]);
            bts_pkg::CSR_FAST_MODE:  fast_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.width  = eff_size(width_ff, bts_pkg::MAX_WIDTH);
      cfg.height = eff_size(height_ff, bts_pkg::MAX_HEIGHT);
      cfg.h_mode = h_mode_ff;
      cfg.v_mode = v_mode_ff;
      cfg.fast   = fast_ff;
   end

   assign committed = {1'b0, f_stat.fill} + {1'b0, q_stat.fill};
   assign req_full  = (committed >= (bts_pkg::CNT_W + 1)'(bts_pkg::MID_DEPTH));
   assign accept    = req_push && !req_full;

   bts_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .accept   (accept),
      .req_item (req_data),
      .stat     (f_stat),
      .out_item (f_item)
   );

   bts_mid_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_stat.push),
      .push_item (f_item),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   bts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_stat    (q_stat),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/bts_front.sv =====
// Front end: coordinate split, per-axis floor division pipeline, edge mapping and addressing.
`timescale 1ns / 1ps
module bts_front (
   input  logic                    clock,
   input  logic                    reset,
   input  bts_pkg::cfg_type        cfg,
   input  logic                    accept,
   input  bts_pkg::req_item_type   req_item,
   output bts_pkg::front_stat_type stat,
   output bts_pkg::mid_item_type   out_item
);

   typedef struct packed {
      logic                            is_load;
      logic [bts_pkg::ADDR_W-1:0]      load_addr;
      logic [bts_pkg::TEXEL_W-1:0]     rgba;
      logic                            span_last;
      logic signed [bts_pkg::IDX_W-1:0] ix;
      logic signed [bts_pkg::IDX_W-1:0] iy;
      logic [bts_pkg::FRAC_BITS-1:0]   fx;
      logic [bts_pkg::FRAC_BITS-1:0]   fy;
      logic [bts_pkg::N_W-1:0]         nx;
      logic [bts_pkg::N_W-1:0]         ny;
      logic                            negx;
      logic                            negy;
      logic [bts_pkg::SIZE_W-1:0]      remx;
      logic [bts_pkg::SIZE_W-1:0]      remy;
      logic                            qx;
      logic                            qy;
   } div_item_type;

   typedef struct packed {
      logic                                  is_load;
      logic [bts_pkg::ADDR_W-1:0]            load_addr;
      logic [bts_pkg::TEXEL_W-1:0]           rgba;
      logic                                  span_last;
      bts_pkg::pick_type                     px0;
      bts_pkg::pick_type                     px1;
      bts_pkg::pick_type                     py0;
      bts_pkg::pick_type                     py1;
      logic [3:0][bts_pkg::WGT_W-1:0]        wgt;
   } map_item_type;

   localparam int ONE = 1 << bts_pkg::FRAC_BITS;
   localparam int HALF = ONE / 2;

   function automatic logic [bts_pkg::SIZE_W:0] div_part(logic [bts_pkg::SIZE_W-1:0] rem,
                                                         logic nbit);
      div_part = {rem, nbit};
   endfunction

   function automatic div_item_type div_step(div_item_type a, logic [bts_pkg::SIZE_W-1:0] sw,
                                             logic [bts_pkg::SIZE_W-1:0] sh);
      div_item_type r;
      logic [bts_pkg::SIZE_W:0] px;
      logic [bts_pkg::SIZE_W:0] py;
      r = a;
      px = div_part(a.remx, a.nx[bts_pkg::N_W-1]);
      py = div_part(a.remy, a.ny[bts_pkg::N_W-1]);
      r.qx = (px >= {1'b0, sw});
      r.qy = (py >= {1'b0, sh});
      if (r.qx) begin
         px = px - {1'b0, sw};
      end
      if (r.qy) begin
         py = py - {1'b0, sh};
      end
      r.remx = px[bts_pkg::SIZE_W-1:0];
      r.remy = py[bts_pkg::SIZE_W-1:0];
      r.nx = {a.nx[bts_pkg::N_W-2:0], 1'b0};
      r.ny = {a.ny[bts_pkg::N_W-2:0], 1'b0};
      return r;
   endfunction

   function automatic bts_pkg::pick_type pick(logic signed [bts_pkg::IDX_W:0] j,
                                              logic [bts_pkg::SIZE_W-1:0] m, logic par,
                                              logic [bts_pkg::SIZE_W-1:0] s,
                                              bts_pkg::mode_type mode);
      bts_pkg::pick_type r;
      logic [bts_pkg::SIZE_W-1:0] top;
      logic signed [bts_pkg::IDX_W:0] ss;
      top = s - 1'b1;
      ss = $signed({{(bts_pkg::IDX_W + 1 - bts_pkg::SIZE_W){1'b0}}, s});
      r.ok = 1'b1;
      unique case (mode)
         bts_pkg::MODE_PAD: begin
            if (j[bts_pkg::IDX_W]) begin
               r.pos = '0;
            end else if (j >= ss) begin
               r.pos = top[bts_pkg::POS_W-1:0];
            end else begin
               r.pos = j[bts_pkg::POS_W-1:0];
            end
         end
         bts_pkg::MODE_REFLECT: begin
            r.pos = par ? bts_pkg::POS_W'(top - m) : m[bts_pkg::POS_W-1:0];
         end
         bts_pkg::MODE_REPEAT: begin
            r.pos = m[bts_pkg::POS_W-1:0];
         end
         bts_pkg::MODE_NONE: begin
            r.pos = j[bts_pkg::POS_W-1:0];
            r.ok = !j[bts_pkg::IDX_W] && (j < ss);
         end
      endcase
      return r;
   endfunction

   div_item_type                 div_ff [0:bts_pkg::N_W];
   div_item_type                 div_in [0:bts_pkg::N_W];
   logic [bts_pkg::N_W:0]        div_vld_ff;
   map_item_type                 map_ff;
   map_item_type                 map_in;
   logic                         map_vld_ff;
   bts_pkg::mid_item_type        adr_ff;
   bts_pkg::mid_item_type        adr_in;
   logic                         adr_vld_ff;
   logic [bts_pkg::CNT_W-1:0]    cnt_ff;
   logic [bts_pkg::CNT_W-1:0]    cnt_in;

   logic signed [bts_pkg::XH_W-1:0] xh;
   logic signed [bts_pkg::XH_W-1:0] yh;

   always_comb begin
      xh = $signed({req_item.coord_x[bts_pkg::CRD_W-1], req_item.coord_x})
           - $signed(bts_pkg::XH_W'(HALF));
      yh = $signed({req_item.coord_y[bts_pkg::CRD_W-1], req_item.coord_y})
           - $signed(bts_pkg::XH_W'(HALF));
      div_in[0].is_load   = (req_item.req_type == bts_pkg::REQ_LOAD);
      div_in[0].load_addr = req_item.texel_addr;
      div_in[0].rgba      = req_item.texel_rgba;
      div_in[0].span_last = req_item.span_last;
      div_in[0].ix        = xh[bts_pkg::XH_W-1:bts_pkg::FRAC_BITS];
      div_in[0].iy        = yh[bts_pkg::XH_W-1:bts_pkg::FRAC_BITS];
      div_in[0].fx        = xh[bts_pkg::FRAC_BITS-1:0];
      div_in[0].fy        = yh[bts_pkg::FRAC_BITS-1:0];
      div_in[0].negx      = xh[bts_pkg::XH_W-1];
      div_in[0].negy      = yh[bts_pkg::XH_W-1];
      div_in[0].nx        = xh[bts_pkg::XH_W-1] ? ~xh[bts_pkg::XH_W-2:bts_pkg::FRAC_BITS]
                                                :  xh[bts_pkg::XH_W-2:bts_pkg::FRAC_BITS];
      div_in[0].ny        = yh[bts_pkg::XH_W-1] ? ~yh[bts_pkg::XH_W-2:bts_pkg::FRAC_BITS]
                                                :  yh[bts_pkg::XH_W-2:bts_pkg::FRAC_BITS];
      div_in[0].remx      = '0;
      div_in[0].remy      = '0;
      div_in[0].qx        = 1'b0;
      div_in[0].qy        = 1'b0;
      for (int k = 0; k < bts_pkg::N_W; k++) begin
         div_in[k + 1] = div_step(div_ff[k], cfg.width, cfg.height);
      end
   end

   // floor remainder, quotient parity, edge mapping and weights for the index and its right or lower neighbour
   always_comb begin
      div_item_type d;
      logic [bts_pkg::SIZE_W-1:0] mx0, mx1, my0, my1;
      logic px0, px1, py0, py1, wx, wy;
      logic signed [bts_pkg::IDX_W:0] jx0, jx1, jy0, jy1;
      logic [bts_pkg::FRAC_BITS:0] ifx, ify, fxe, fye;
      logic [2*bts_pkg::FRAC_BITS+1:0] p0, p1, p2, p3;
      d = div_ff[bts_pkg::N_W];
      mx0 = d.negx ? (cfg.width - 1'b1 - d.remx) : d.remx;
      my0 = d.negy ? (cfg.height - 1'b1 - d.remy) : d.remy;
      px0 = d.negx ^ d.qx;
      py0 = d.negy ^ d.qy;
      mx1 = mx0 + 1'b1;
      my1 = my0 + 1'b1;
      wx = (mx1 == cfg.width);
      wy = (my1 == cfg.height);
      if (wx) begin
         mx1 = '0;
      end
      if (wy) begin
         my1 = '0;
      end
      px1 = px0 ^ wx;
      py1 = py0 ^ wy;
      jx0 = {d.ix[bts_pkg::IDX_W-1], d.ix};
      jy0 = {d.iy[bts_pkg::IDX_W-1], d.iy};
      jx1 = jx0 + $signed((bts_pkg::IDX_W + 1)'(1));
      jy1 = jy0 + $signed((bts_pkg::IDX_W + 1)'(1));
      fxe = {1'b0, d.fx};
      fye = {1'b0, d.fy};
      ifx = (bts_pkg::FRAC_BITS + 1)'(ONE) - fxe;
      ify = (bts_pkg::FRAC_BITS + 1)'(ONE) - fye;
      p0 = ifx * ify;
      p1 = fxe * ify;
      p2 = ifx * fye;
      p3 = fxe * fye;
      map_in.is_load   = d.is_load;
      map_in.load_addr = d.load_addr;
      map_in.rgba      = d.rgba;
      map_in.span_last = d.span_last;
      map_in.px0 = pick(jx0, mx0, px0, cfg.width, cfg.h_mode);
      map_in.px1 = pick(jx1, mx1, px1, cfg.width, cfg.h_mode);
      map_in.py0 = pick(jy0, my0, py0, cfg.height, cfg.v_mode);
      map_in.py1 = pick(jy1, my1, py1, cfg.height, cfg.v_mode);
      map_in.wgt[0] = p0[bts_pkg::WGT_W-1:0];
      map_in.wgt[1] = p1[bts_pkg::WGT_W-1:0];
      map_in.wgt[2] = p2[bts_pkg::WGT_W-1:0];
      map_in.wgt[3] = p3[bts_pkg::WGT_W-1:0];
   end

   always_comb begin
      logic [bts_pkg::AM_W-1:0] r0, r1;
      r0 = bts_pkg::AM_W'(map_ff.py0.pos) * bts_pkg::AM_W'(cfg.width);
      r1 = bts_pkg::AM_W'(map_ff.py1.pos) * bts_pkg::AM_W'(cfg.width);
      adr_in.is_load   = map_ff.is_load;
      adr_in.load_addr = map_ff.load_addr;
      adr_in.rgba      = map_ff.rgba;
      adr_in.span_last = map_ff.span_last;
      adr_in.wgt       = map_ff.wgt;
      adr_in.addr[0] = bts_pkg::ADDR_W'(r0 + bts_pkg::AM_W'(map_ff.px0.pos));
      adr_in.addr[1] = bts_pkg::ADDR_W'(r0 + bts_pkg::AM_W'(map_ff.px1.pos));
      adr_in.addr[2] = bts_pkg::ADDR_W'(r1 + bts_pkg::AM_W'(map_ff.px0.pos));
      adr_in.addr[3] = bts_pkg::ADDR_W'(r1 + bts_pkg::AM_W'(map_ff.px1.pos));
      adr_in.ok[0] = map_ff.px0.ok & map_ff.py0.ok;
      adr_in.ok[1] = map_ff.px1.ok & map_ff.py0.ok;
      adr_in.ok[2] = map_ff.px0.ok & map_ff.py1.ok;
      adr_in.ok[3] = map_ff.px1.ok & map_ff.py1.ok;
   end

   always_comb begin
      cnt_in = cnt_ff;
      case ({accept, adr_vld_ff})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff <= '0;
         map_vld_ff <= 1'b0;
         adr_vld_ff <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         div_vld_ff <= {div_vld_ff[bts_pkg::N_W-1:0], accept};
         map_vld_ff <= div_vld_ff[bts_pkg::N_W];
         adr_vld_ff <= map_vld_ff;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= bts_pkg::N_W; k++) begin
         div_ff[k] <= div_in[k];
      end
      map_ff <= map_in;
      adr_ff <= adr_in;
   end

   assign stat.push = adr_vld_ff;
   assign stat.fill = cnt_ff;
   assign out_item  = adr_ff;

endmodule

// ===== hdl/bts_mid_queue.sv =====
// Queue between the front end and the texel back end.
`timescale 1ns / 1ps
module bts_mid_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  bts_pkg::mid_item_type   push_item,
   input  logic                    pop,
   output bts_pkg::mid_item_type   head,
   output bts_pkg::queue_stat_type stat
);

   bts_pkg::mid_item_type          mem_ff [0:bts_pkg::MID_DEPTH-1];
   logic [bts_pkg::MID_PTR_W-1:0]  wr_ptr_ff;
   logic [bts_pkg::MID_PTR_W-1:0]  rd_ptr_ff;
   logic [bts_pkg::CNT_W-1:0]      cnt_ff;
   logic [bts_pkg::CNT_W-1:0]      cnt_in;

   always_comb begin
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head       = mem_ff[rd_ptr_ff];
   assign stat.empty = (cnt_ff == '0);
   assign stat.fill  = cnt_ff;

endmodule

// ===== hdl/bts_back.sv =====
// Back end: texel store, four-texel fetch, bilinear blend (or the first texel in fast mode) and result queue.
`timescale 1ns / 1ps
module bts_back (
   input  logic                    clock,
   input  logic                    reset,
   input  bts_pkg::cfg_type        cfg,
   input  bts_pkg::queue_stat_type q_stat,
   input  bts_pkg::mid_item_type   q_head,
   output logic                    q_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output bts_pkg::rsp_item_type   rsp_data
);

   localparam int STORE_DEPTH = 1 << bts_pkg::ADDR_W;
   localparam int ROUND = 1 << (2 * bts_pkg::FRAC_BITS - 1);

   logic [bts_pkg::TEXEL_W-1:0]            mem_a [0:STORE_DEPTH-1];
   logic [bts_pkg::TEXEL_W-1:0]            mem_b [0:STORE_DEPTH-1];
   logic [3:0][bts_pkg::TEXEL_W-1:0]       rd_ff;
   bts_pkg::mid_item_type                  b1_ff;
   logic                                   b1_vld_ff;
   logic [3:0][3:0][bts_pkg::PROD_W-1:0]   prod_ff;
   logic [3:0][3:0][bts_pkg::PROD_W-1:0]   prod_in;
   logic [bts_pkg::TEXEL_W-1:0]            t0_ff;
   logic [3:0][bts_pkg::TEXEL_W-1:0]       tex;
   logic                                   last_ff;
   logic                                   b2_vld_ff;
   bts_pkg::rsp_item_type                  res;
   bts_pkg::rsp_item_type                  out_ff [0:bts_pkg::OUT_DEPTH-1];
   logic [bts_pkg::OUT_PTR_W-1:0]          owr_ff;
   logic [bts_pkg::OUT_PTR_W-1:0]          ord_ff;
   logic [bts_pkg::OCNT_W-1:0]             ocnt_ff;
   logic [bts_pkg::OCNT_W-1:0]             ocnt_in;
   logic [bts_pkg::OCNT_W:0]               in_flight;
   logic                                   out_pop;
   logic                                   q_sample;

   assign q_sample  = q_pop && !q_head.is_load;
   assign in_flight = bts_pkg::OCNT_W'(0) + {1'b0, ocnt_ff}
                      + (bts_pkg::OCNT_W + 1)'(b1_vld_ff) + (bts_pkg::OCNT_W + 1)'(b2_vld_ff);
   assign q_pop     = !q_stat.empty
                      && (q_head.is_load || (in_flight < (bts_pkg::OCNT_W + 1)'(bts_pkg::OUT_DEPTH)));
   assign out_pop   = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (q_pop && q_head.is_load) begin
         mem_a[q_head.load_addr] <= q_head.rgba;
         mem_b[q_head.load_addr] <= q_head.rgba;
      end
      if (q_pop) begin
         rd_ff[0] <= mem_a[q_head.addr[0]];
         rd_ff[1] <= mem_a[q_head.addr[1]];
         rd_ff[2] <= mem_b[q_head.addr[2]];
         rd_ff[3] <= mem_b[q_head.addr[3]];
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         tex[k] = b1_ff.ok[k] ? rd_ff[k] : '0;
         for (int c = 0; c < 4; c++) begin
            prod_in[k][c] = bts_pkg::PROD_W'(b1_ff.wgt[k])
                            * bts_pkg::PROD_W'(tex[k][bts_pkg::CHAN_W*c +: bts_pkg::CHAN_W]);
         end
      end
   end

   always_comb begin
      logic [3:0][bts_pkg::CHAN_W-1:0] ch;
      logic [bts_pkg::ACC_W-1:0] acc;
      for (int c = 0; c < 4; c++) begin
         acc = bts_pkg::ACC_W'(ROUND);
         for (int k = 0; k < 4; k++) begin
            acc = acc + bts_pkg::ACC_W'(prod_ff[k][c]);
         end
         ch[c] = cfg.fast ? t0_ff[bts_pkg::CHAN_W*c +: bts_pkg::CHAN_W]
                          : acc[2*bts_pkg::FRAC_BITS +: bts_pkg::CHAN_W];
      end
      res.red      = ch[0];
      res.green    = ch[1];
      res.blue     = ch[2];
      res.alpha    = ch[3];
      res.span_end = last_ff;
   end

   always_comb begin
      case ({b2_vld_ff, out_pop})
         2'b10:   ocnt_in = ocnt_ff + 1'b1;
         2'b01:   ocnt_in = ocnt_ff - 1'b1;
         default: ocnt_in = ocnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff <= 1'b0;
         b2_vld_ff <= 1'b0;
         owr_ff    <= '0;
         ord_ff    <= '0;
         ocnt_ff   <= '0;
      end else begin
         b1_vld_ff <= q_sample;
         b2_vld_ff <= b1_vld_ff;
         if (b2_vld_ff) begin
            owr_ff <= owr_ff + 1'b1;
         end
         if (out_pop) begin
            ord_ff <= ord_ff + 1'b1;
         end
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      b1_ff   <= q_head;
      prod_ff <= prod_in;
      t0_ff   <= tex[0];
      last_ff <= b1_ff.span_last;
      if (b2_vld_ff) begin
         out_ff[owr_ff] <= res;
      end
   end

   assign rsp_empty = (ocnt_ff == '0);
   assign rsp_data  = out_ff[ord_ff];

   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= bts_pkg::OCNT_W'(bts_pkg::OUT_DEPTH))
      else $error("result queue over capacity");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      b2_vld_ff |-> (ocnt_ff < bts_pkg::OCNT_W'(bts_pkg::OUT_DEPTH)) || out_pop)
      else $error("blend result pushed into full result queue");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("mid queue popped while empty");

   a_sample_flow: assert property (@(posedge clock) disable iff (reset)
      q_sample |=> b1_vld_ff ##1 b2_vld_ff)
      else $error("sample lost in back end pipeline");

endmodule
